### hdl/ltc_pkg.sv
// Package with the shared types, constants and helpers of the lightmap texel combiner.
`default_nettype none
package ltc_pkg;

  localparam int unsigned NumLayers  = 4;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned RgbW       = 24;
  localparam int unsigned AccW       = 32;
  localparam int unsigned ScaleW     = 10;
  localparam int unsigned ProdW      = ByteW + ScaleW;
  localparam int unsigned ActiveW    = 3;
  localparam int unsigned FmtW       = 2;
  localparam int unsigned ShiftW     = 5;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 10;
  localparam int unsigned CountW     = 3;

  localparam logic [AccW-1:0]   FullBright = AccW'(255 * 256);
  localparam logic [ByteW-1:0]  ByteMax    = 8'hFF;
  localparam logic [AccW-1:0]   LumWeight  = AccW'(85);
  localparam logic [AccW-1:0]   AlphaOpaque = AccW'(255) << 24;

  localparam logic [FmtW-1:0] FMT_RGB  = 2'd0;
  localparam logic [FmtW-1:0] FMT_RGBA = 2'd1;
  localparam logic [FmtW-1:0] FMT_LUM  = 2'd2;

  localparam logic [CountW-1:0] CNT_RGB  = 3'd3;
  localparam logic [CountW-1:0] CNT_RGBA = 3'd4;
  localparam logic [CountW-1:0] CNT_LUM  = 3'd1;

  localparam logic [CfgIdxW-1:0] REG_SCALE0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCALE1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCALE2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SCALE3 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FORMAT = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SHIFT  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_LIGHT  = 3'd7;

  typedef struct packed {
    logic [NumLayers-1:0][ScaleW-1:0] scale;
    logic [ActiveW-1:0]               active;
    logic [FmtW-1:0]                  format;
    logic [ShiftW-1:0]                shift;
    logic                             has_light;
  } cfg_t;

  typedef struct packed {
    logic [NumLayers-1:0][RgbW-1:0] layer_rgb;
    logic [RgbW-1:0]                stain_rgb;
    logic [NumChan-1:0][AccW-1:0]   dyn;
  } texel_t;

  function automatic logic [ByteW-1:0] sat_byte(input logic [AccW-1:0] v,
                                                input logic [ShiftW-1:0] sh);
    logic [AccW-1:0] t;
    t = v >> sh;
    return (|t[AccW-1:ByteW]) ? ByteMax : t[ByteW-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/ltc_if.sv
// Channel interfaces for texel input, pixel output and configuration writes.
`default_nettype none
interface ltc_texel_if;
  logic        valid;
  logic        ready;
  logic [23:0] layer0_rgb;
  logic [23:0] layer1_rgb;
  logic [23:0] layer2_rgb;
  logic [23:0] layer3_rgb;
  logic [23:0] stain_rgb;
  logic [31:0] dyn_red;
  logic [31:0] dyn_green;
  logic [31:0] dyn_blue;
  modport source (output valid, layer0_rgb, layer1_rgb, layer2_rgb, layer3_rgb,
                  stain_rgb, dyn_red, dyn_green, dyn_blue, input ready);
  modport sink (input valid, layer0_rgb, layer1_rgb, layer2_rgb, layer3_rgb,
                stain_rgb, dyn_red, dyn_green, dyn_blue, output ready);
endinterface

interface ltc_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic [2:0]  byte_count;
  modport source (output valid, pixel_word, byte_count, input ready);
  modport sink (input valid, pixel_word, byte_count, output ready);
endinterface

interface ltc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/ltc_cfg_regs.sv
// Configuration register file of the lightmap texel combiner.
`default_nettype none
module ltc_cfg_regs import ltc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (wr_index_i)
        REG_SCALE0: cfg_d.scale[0] = wr_data_i[ScaleW-1:0];
        REG_SCALE1: cfg_d.scale[1] = wr_data_i[ScaleW-1:0];
        REG_SCALE2: cfg_d.scale[2] = wr_data_i[ScaleW-1:0];
        REG_SCALE3: cfg_d.scale[3] = wr_data_i[ScaleW-1:0];
        REG_ACTIVE: cfg_d.active   = wr_data_i[ActiveW-1:0];
        REG_FORMAT: cfg_d.format   = wr_data_i[FmtW-1:0];
        REG_SHIFT:  cfg_d.shift    = wr_data_i[ShiftW-1:0];
        REG_LIGHT:  cfg_d.has_light = wr_data_i[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale     <= {NumLayers{ScaleW'(256)}};
      cfg_q.active    <= ActiveW'(1);
      cfg_q.format    <= FMT_RGB;
      cfg_q.shift     <= ShiftW'(9);
      cfg_q.has_light <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

### hdl/ltc_scale.sv
// First pipeline stage: style sample bytes times style scale.
`default_nettype none
module ltc_scale import ltc_pkg::*; #(
  parameter int unsigned MaxStyles = 4
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  texel_t                                    texel_i,
  input  cfg_t                                      cfg_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output logic [MaxStyles-1:0][NumChan-1:0][ProdW-1:0] prod_o,
  output logic [RgbW-1:0]                           stain_o,
  output logic [NumChan-1:0][AccW-1:0]              dyn_o
);

  logic                                         valid_q;
  logic [MaxStyles-1:0][NumChan-1:0][ProdW-1:0] prod_q, prod_d;
  logic [RgbW-1:0]                              stain_q;
  logic [NumChan-1:0][AccW-1:0]                 dyn_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int k = 0; k < MaxStyles; k++) begin
      for (int c = 0; c < NumChan; c++) begin
        prod_d[k][c] = ProdW'(texel_i.layer_rgb[k][c*ByteW +: ByteW]) *
                       ProdW'(cfg_i.scale[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q  <= prod_d;
      stain_q <= texel_i.stain_rgb;
      dyn_q   <= texel_i.dyn;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign stain_o = stain_q;
  assign dyn_o   = dyn_q;

endmodule
`default_nettype wire

### hdl/ltc_accum.sv
// Stage two: per channel dyn light plus active style products; FullBright if unlit.
`default_nettype none
module ltc_accum import ltc_pkg::*; #(
  parameter int unsigned MaxStyles = 4
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  output logic                                         ready_o,
  input  logic [MaxStyles-1:0][NumChan-1:0][ProdW-1:0] prod_i,
  input  logic [RgbW-1:0]                              stain_i,
  input  logic [NumChan-1:0][AccW-1:0]                 dyn_i,
  input  cfg_t                                         cfg_i,
  output logic                                         valid_o,
  input  logic                                         ready_i,
  output logic [NumChan-1:0][AccW-1:0]                 sum_o,
  output logic [RgbW-1:0]                              stain_o
);

  localparam logic [ActiveW-1:0] StyleLimit = ActiveW'(MaxStyles);

  logic                         valid_q;
  logic [NumChan-1:0][AccW-1:0] sum_q, sum_d;
  logic [RgbW-1:0]              stain_q;
  logic [ActiveW-1:0]           layers;

  assign ready_o = !valid_q || ready_i;
  assign layers  = (cfg_i.active > StyleLimit) ? StyleLimit : cfg_i.active;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      sum_d[c] = dyn_i[c];
      for (int k = 0; k < MaxStyles; k++) begin
        if (ActiveW'(k) < layers) begin
          sum_d[c] = sum_d[c] + AccW'(prod_i[k][c]);
        end
      end
      if (!cfg_i.has_light) begin
        sum_d[c] = FullBright;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sum_q   <= sum_d;
      stain_q <= stain_i;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign stain_o = stain_q;

endmodule
`default_nettype wire

### hdl/ltc_pack.sv
// Third and fourth pipeline stages: stain and luminance products, shift, saturate and pack.
`default_nettype none
module ltc_pack import ltc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [NumChan-1:0][AccW-1:0] sum_i,
  input  logic [RgbW-1:0]              stain_i,
  input  cfg_t                         cfg_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [AccW-1:0]              pixel_word_o,
  output logic [CountW-1:0]            byte_count_o
);

  logic                         mul_valid_q;
  logic                         mul_ready;
  logic [NumChan-1:0][AccW-1:0] stained_q, stained_d;
  logic [AccW-1:0]              lum_sum_q, lum_sum_d;

  logic                         out_valid_q;
  logic [AccW-1:0]              word_q, word_d;
  logic [CountW-1:0]            count_q, count_d;
  logic [AccW-1:0]              lum;

  assign mul_ready = !out_valid_q || ready_i;
  assign ready_o   = !mul_valid_q || mul_ready;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      stained_d[c] = sum_i[c] * AccW'(stain_i[c*ByteW +: ByteW]);
    end
    lum_sum_d = sum_i[0] + sum_i[1] + sum_i[2];
  end

  always_comb begin
    lum     = lum_sum_q * LumWeight;
    word_d  = '0;
    count_d = CNT_RGB;
    case (cfg_i.format)
      FMT_LUM: begin
        word_d  = AccW'(sat_byte(lum, cfg_i.shift));
        count_d = CNT_LUM;
      end
      FMT_RGBA: begin
        for (int c = 0; c < NumChan; c++) begin
          word_d[c*ByteW +: ByteW] = sat_byte(stained_q[c], cfg_i.shift);
        end
        word_d  = word_d | AlphaOpaque;
        count_d = CNT_RGBA;
      end
      default: begin
        for (int c = 0; c < NumChan; c++) begin
          word_d[c*ByteW +: ByteW] = sat_byte(stained_q[c], cfg_i.shift);
        end
        count_d = CNT_RGB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        mul_valid_q <= valid_i;
      end
      if (mul_ready) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stained_q <= stained_d;
      lum_sum_q <= lum_sum_d;
    end
    if (mul_ready && mul_valid_q) begin
      word_q  <= word_d;
      count_q <= count_d;
    end
  end

  assign valid_o      = out_valid_q;
  assign pixel_word_o = word_q;
  assign byte_count_o = count_q;

endmodule
`default_nettype wire

### hdl/lightmap_texel_combiner_core.sv
// Top level of the lightmap texel combiner: config registers and a four stage pipeline.
// Each accepted texel beat passes the scale, accumulate, multiply and output registers in order to its pixel beat.
// Throughput: one texel per cycle while the output is ready; every stage takes a new beat whenever the next one can.
// Backpressure stalls each full stage whose following stages are all full; empty stages keep filling.
// Reset: clears all stage valid bits and loads the register reset values.
`default_nettype none
module lightmap_texel_combiner_core import ltc_pkg::*; #(
  parameter int unsigned MAX_STYLES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ltc_texel_if.sink   in_i,
  ltc_pixel_if.source out_o,
  ltc_cfg_if.sink     cfg_i
);

  cfg_t   cfg;
  texel_t texel;

  logic                                          s1_valid, s1_ready;
  logic [MAX_STYLES-1:0][NumChan-1:0][ProdW-1:0] s1_prod;
  logic [RgbW-1:0]                               s1_stain;
  logic [NumChan-1:0][AccW-1:0]                  s1_dyn;

  logic                                          s2_valid, s2_ready;
  logic [NumChan-1:0][AccW-1:0]                  s2_sum;
  logic [RgbW-1:0]                               s2_stain;

  assign texel.layer_rgb[0] = in_i.layer0_rgb;
  assign texel.layer_rgb[1] = in_i.layer1_rgb;
  assign texel.layer_rgb[2] = in_i.layer2_rgb;
  assign texel.layer_rgb[3] = in_i.layer3_rgb;
  assign texel.stain_rgb    = in_i.stain_rgb;
  assign texel.dyn[0]       = in_i.dyn_red;
  assign texel.dyn[1]       = in_i.dyn_green;
  assign texel.dyn[2]       = in_i.dyn_blue;

  ltc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  ltc_scale #(.MaxStyles(MAX_STYLES)) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .texel_i (texel),
    .cfg_i   (cfg),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .prod_o  (s1_prod),
    .stain_o (s1_stain),
    .dyn_o   (s1_dyn)
  );

  ltc_accum #(.MaxStyles(MAX_STYLES)) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .prod_i  (s1_prod),
    .stain_i (s1_stain),
    .dyn_i   (s1_dyn),
    .cfg_i   (cfg),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .sum_o   (s2_sum),
    .stain_o (s2_stain)
  );

  ltc_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s2_valid),
    .ready_o      (s2_ready),
    .sum_i        (s2_sum),
    .stain_i      (s2_stain),
    .cfg_i        (cfg),
    .valid_o      (out_o.valid),
    .ready_i      (out_o.ready),
    .pixel_word_o (out_o.pixel_word),
    .byte_count_o (out_o.byte_count)
  );

endmodule
`default_nettype wire

### test/lightmap_texel_combiner_core_tb.sv
// Lightmap texel combiner testbench: directed and random texel/pixel traffic vs. a predictor.
`timescale 1ns / 100ps
module lightmap_texel_combiner_core_tb;
  import ltc_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ltc_texel_if texel_bus ();
  ltc_pixel_if pixel_bus ();
  ltc_cfg_if   cfg_bus ();

  lightmap_texel_combiner_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (texel_bus),
    .out_o  (pixel_bus),
    .cfg_i  (cfg_bus)
  );

  texel_t pending_texels [$];
  pixel_t expected_pixels [$];
  cfg_t   light_cfg;

  int  mismatches = 0;
  int  src_gap = 0;
  int  rx_stall = 0;
  int  hold_req = 0;
  int  hold_ack = 0;
  bit  src_gaps_on = 1'b0;
  bit  snk_gaps_on = 1'b0;
  logic texel_beat = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] clamp_byte(logic [31:0] v);
    logic [31:0] s;
    s = v >> light_cfg.shift;
    return (s > 32'd255) ? ByteMax : s[7:0];
  endfunction

  function automatic pixel_t blend_texel(texel_t t);
    logic [31:0] acc [3];
    logic [2:0]  layers;
    pixel_t      px;
    px.word = '0;
    layers = (light_cfg.active > 3'd4) ? 3'd4 : light_cfg.active;
    for (int c = 0; c < 3; c++) begin
      acc[c] = light_cfg.has_light ? t.dyn[c] : FullBright;
    end
    if (light_cfg.has_light) begin
      for (int k = 0; k < 4; k++) begin
        if (k < layers) begin
          for (int c = 0; c < 3; c++) begin
            acc[c] += 32'(t.layer_rgb[k][8*c +: 8]) * 32'(light_cfg.scale[k]);
          end
        end
      end
    end
    if (light_cfg.format == FMT_LUM) begin
      px.word[7:0] = clamp_byte((acc[0] + acc[1] + acc[2]) * LumWeight);
      px.count = CNT_LUM;
    end else begin
      for (int c = 0; c < 3; c++) begin
        px.word[8*c +: 8] = clamp_byte(acc[c] * 32'(t.stain_rgb[8*c +: 8]));
      end
      if (light_cfg.format == FMT_RGBA) begin
        px.word[31:24] = ByteMax;
        px.count = CNT_RGBA;
      end else begin
        px.count = CNT_RGB;
      end
    end
    return px;
  endfunction

  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // texel side: hold an offered beat until it is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      texel_bus.valid <= 1'b0;
    end else if (texel_bus.valid && !texel_beat) begin
    end else if (src_gap != 0) begin
      texel_bus.valid <= 1'b0;
      src_gap <= src_gap - 1;
    end else if (pending_texels.size() != 0) begin
      texel_bus.valid      <= 1'b1;
      texel_bus.layer0_rgb <= pending_texels[0].layer_rgb[0];
      texel_bus.layer1_rgb <= pending_texels[0].layer_rgb[1];
      texel_bus.layer2_rgb <= pending_texels[0].layer_rgb[2];
      texel_bus.layer3_rgb <= pending_texels[0].layer_rgb[3];
      texel_bus.stain_rgb  <= pending_texels[0].stain_rgb;
      texel_bus.dyn_red    <= pending_texels[0].dyn[0];
      texel_bus.dyn_green  <= pending_texels[0].dyn[1];
      texel_bus.dyn_blue   <= pending_texels[0].dyn[2];
      src_gap <= pick_gap(src_gaps_on);
    end else begin
      texel_bus.valid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    texel_beat <= texel_bus.valid && texel_bus.ready;
    if (rst_ni && texel_bus.valid && texel_bus.ready) begin
      expected_pixels.push_back(blend_texel(pending_texels.pop_front()));
    end
  end

  // pixel side: random stalls plus a single long hold
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      rx_stall <= 120;
      pixel_bus.ready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      pixel_bus.ready <= 1'b0;
    end else if (snk_gaps_on && $urandom_range(0, 3) == 0) begin
      rx_stall <= pick_gap(1'b1);
      pixel_bus.ready <= 1'b0;
    end else begin
      pixel_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pixel_bus.valid && pixel_bus.ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected pixel beat: word %h count %0d",
                   pixel_bus.pixel_word, pixel_bus.byte_count);
        end
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_bus.pixel_word !== want.word || pixel_bus.byte_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel mismatch: expected word %h count %0d, got word %h count %0d",
                     want.word, want.count, pixel_bus.pixel_word, pixel_bus.byte_count);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      REG_SCALE0: light_cfg.scale[0] = val;
      REG_SCALE1: light_cfg.scale[1] = val;
      REG_SCALE2: light_cfg.scale[2] = val;
      REG_SCALE3: light_cfg.scale[3] = val;
      REG_ACTIVE: light_cfg.active = val[2:0];
      REG_FORMAT: light_cfg.format = val[1:0];
      REG_SHIFT:  light_cfg.shift = val[4:0];
      REG_LIGHT:  light_cfg.has_light = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // write every register, with junk in the unused upper bits
  task automatic apply_cfg(cfg_t c);
    write_reg(REG_SCALE0, c.scale[0]);
    write_reg(REG_SCALE1, c.scale[1]);
    write_reg(REG_SCALE2, c.scale[2]);
    write_reg(REG_SCALE3, c.scale[3]);
    write_reg(REG_ACTIVE, {7'($urandom), c.active});
    write_reg(REG_FORMAT, {8'($urandom), c.format});
    write_reg(REG_SHIFT,  {5'($urandom), c.shift});
    write_reg(REG_LIGHT,  {9'($urandom), c.has_light});
  endtask

  function automatic cfg_t cfg_of(logic [9:0] scl, logic [2:0] act, logic [1:0] fmt,
                                  logic [4:0] sh, logic lit);
    cfg_t c;
    for (int k = 0; k < 4; k++) c.scale[k] = scl;
    c.active = act;
    c.format = fmt;
    c.shift = sh;
    c.has_light = lit;
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int   r;
    for (int k = 0; k < 4; k++) begin
      r = $urandom_range(0, 3);
      c.scale[k] = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : 10'($urandom_range(0, 1023));
    end
    c.active = 3'($urandom_range(0, 7));
    c.format = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 5);
    c.shift = (r == 0) ? 5'd0 : (r == 1) ? 5'd31 : 5'($urandom_range(4, 20));
    c.has_light = ($urandom_range(0, 9) != 0);
    return c;
  endfunction

  function automatic logic [23:0] rand_rgb();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 24'h000000;
    if (r == 1) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  function automatic logic [31:0] rand_dyn();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFFFFFF;
    if (r < 6) return 32'($urandom_range(0, 65535));
    return $urandom;
  endfunction

  task automatic push_texel(logic [23:0] l0, logic [23:0] l1, logic [23:0] l2,
                            logic [23:0] l3, logic [23:0] stain,
                            logic [31:0] r, logic [31:0] g, logic [31:0] b);
    texel_t t;
    t.layer_rgb[0] = l0;
    t.layer_rgb[1] = l1;
    t.layer_rgb[2] = l2;
    t.layer_rgb[3] = l3;
    t.stain_rgb = stain;
    t.dyn[0] = r;
    t.dyn[1] = g;
    t.dyn[2] = b;
    pending_texels.push_back(t);
  endtask

  task automatic wait_idle();
    while (pending_texels.size() != 0 || expected_pixels.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    texel_bus.valid = 1'b0;
    texel_bus.layer0_rgb = '0;
    texel_bus.layer1_rgb = '0;
    texel_bus.layer2_rgb = '0;
    texel_bus.layer3_rgb = '0;
    texel_bus.stain_rgb = '0;
    texel_bus.dyn_red = '0;
    texel_bus.dyn_green = '0;
    texel_bus.dyn_blue = '0;
    pixel_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    light_cfg = cfg_of(10'd256, 3'd1, FMT_RGB, 5'd9, 1'b1);
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: one layer, RGB, shift 9
    push_texel(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 32'h0, 32'h0);
    push_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
               32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    push_texel(24'h0000FF, 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 32'h0, 32'h0, 32'h0);
    push_texel(24'h804020, 24'h0, 24'h0, 24'h0, 24'h010203, 32'h100, 32'h200, 32'h300);
    push_texel(24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h010101, 32'h0, 32'h1, 32'h2);
    wait_idle();

    apply_cfg(cfg_of(10'd1023, 3'd4, FMT_RGBA, 5'd0, 1'b1));
    push_texel(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 32'h0, 32'h0);
    push_texel(24'h010101, 24'h010101, 24'h010101, 24'h010101, 24'h010101, 32'h0, 32'h0, 32'h0);
    push_texel(24'h0, 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 32'h1, 32'h0, 32'hFF);
    wait_idle();

    apply_cfg(cfg_of(10'd1, 3'd7, FMT_LUM, 5'd31, 1'b1));
    push_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
               32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    push_texel(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 32'h80000000, 32'h0, 32'h0);
    push_texel(24'h000001, 24'h000100, 24'h010000, 24'hFF0000, 24'h0,
               32'h7FFFFFFF, 32'h1, 32'h0);
    wait_idle();

    apply_cfg(cfg_of(10'd0, 3'd0, 2'd3, 5'd16, 1'b0));
    push_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFF0001,
               32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    push_texel(24'h0, 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 32'h0, 32'h0, 32'h0);
    push_texel(24'h123456, 24'h0, 24'h0, 24'h0, 24'h80FF01, 32'h5, 32'h6, 32'h7);
    wait_idle();

    apply_cfg(cfg_of(10'd1023, 3'd4, FMT_LUM, 5'd8, 1'b0));
    push_texel(24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 32'h0, 32'h0);
    wait_idle();
    apply_cfg(cfg_of(10'd0, 3'd2, FMT_RGB, 5'd31, 1'b1));
    push_texel(24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0, 24'hFFFFFF,
               32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    push_texel(24'hABCDEF, 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h1);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      apply_cfg(rand_cfg());
      src_gaps_on = (ph == 0 || ph == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      snk_gaps_on = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (ph == 3) hold_req++;
      for (int n = 0; n < 58; n++) begin
        push_texel(rand_rgb(), rand_rgb(), rand_rgb(), rand_rgb(), rand_rgb(),
                   rand_dyn(), rand_dyn(), rand_dyn());
        if (ph == 7 && n == 29) wait_idle();
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
